// ===== hdl/sha1_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 message hasher.
// Used by sha1_ctrl, sha1_dp and the top level sha1_message_hasher.
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumH    = 5;
  localparam int unsigned FillW   = 6;
  localparam int unsigned LenW    = 64;
  localparam int unsigned RndW    = 7;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned ActW    = 2;
  localparam int unsigned BlkW    = 512;

  localparam logic [ActW-1:0] ACT_ABSORB     = 2'd0;
  localparam logic [ActW-1:0] ACT_ABSORB_FIN = 2'd1;
  localparam logic [ActW-1:0] ACT_FINISH     = 2'd2;

  localparam logic [RndW-1:0]  LastRound  = 7'd79;
  localparam logic [IdxW-1:0]  LastWord   = 3'd4;
  localparam logic [FillW-1:0] FillLast   = 6'd63;
  localparam logic [FillW-1:0] FillLenPos = 6'd56;
  localparam logic [2:0]       LenBytesHi = 3'd7;
  localparam logic [ByteW-1:0] PadMark    = 8'h80;
  localparam logic [ByteW-1:0] PadZero    = 8'h00;

  localparam logic [NumH-1:0][WordW-1:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_e;

  typedef enum logic [1:0] {
    BS_INPUT,
    BS_MARK,
    BS_ZERO,
    BS_LEN
  } byte_sel_e;

  typedef struct packed {
    logic            absorb;
    byte_sel_e       byte_sel;
    logic [2:0]      len_idx;
    logic            count_len;
    logic            round_en;
    logic [RndW-1:0] round_idx;
    logic            fold;
    logic            restart;
    logic [IdxW-1:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
  } dp_sts_t;

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] t);
    logic [WordW-1:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RndW-1:0] t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== hdl/sha1_ctrl.sv =====
// Sequencer for the SHA-1 hasher: request intake, padding, rounds, digest output.
// Depends on sha1_pkg; drives sha1_dp through dp_cmd_t and reads dp_sts_t.
module sha1_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [sha1_pkg::ActW-1:0]   action_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output sha1_pkg::dp_cmd_t           cmd_o,
  input  sha1_pkg::dp_sts_t           sts_i
);

  sha1_pkg::ctrl_state_e           state_q, state_d;
  sha1_pkg::pad_phase_e            phase_q, phase_d;
  logic                            fin_q, fin_d;
  logic [sha1_pkg::RndW-1:0]       rnd_q, rnd_d;
  logic [2:0]                      len_cnt_q, len_cnt_d;
  logic [sha1_pkg::IdxW-1:0]       oidx_q, oidx_d;

  logic in_acc;
  logic out_acc;
  logic act_absorb;
  logic act_fin;
  logic fill_last;
  logic fill_len;

  assign in_acc     = valid_i && (state_q == sha1_pkg::ST_IDLE);
  assign out_acc    = (state_q == sha1_pkg::ST_OUT) && !stall_i;
  assign act_absorb = (action_i == sha1_pkg::ACT_ABSORB) ||
                      (action_i == sha1_pkg::ACT_ABSORB_FIN);
  assign act_fin    = (action_i != sha1_pkg::ACT_ABSORB);
  assign fill_last  = (sts_i.fill == sha1_pkg::FillLast);
  assign fill_len   = (sts_i.fill == sha1_pkg::FillLenPos);

  // next state
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    fin_d     = fin_q;
    rnd_d     = '0;
    len_cnt_d = len_cnt_q;
    oidx_d    = oidx_q;
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        if (in_acc) begin
          fin_d     = act_fin;
          phase_d   = sha1_pkg::PH_MARK;
          len_cnt_d = sha1_pkg::LenBytesHi;
          if (act_absorb && fill_last) begin
            state_d = sha1_pkg::ST_ROUND;
          end else if (act_fin) begin
            state_d = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        unique case (phase_q)
          sha1_pkg::PH_MARK: begin
            phase_d = sha1_pkg::PH_ZERO;
            if (fill_last) state_d = sha1_pkg::ST_ROUND;
          end
          sha1_pkg::PH_ZERO: begin
            if (fill_len) begin
              phase_d = sha1_pkg::PH_LEN;
            end else if (fill_last) begin
              state_d = sha1_pkg::ST_ROUND;
            end
          end
          sha1_pkg::PH_LEN: begin
            len_cnt_d = len_cnt_q - 3'd1;
            if (len_cnt_q == '0) phase_d = sha1_pkg::PH_DONE;
            if (fill_last) state_d = sha1_pkg::ST_ROUND;
          end
          sha1_pkg::PH_DONE: begin
            state_d = sha1_pkg::ST_OUT;
          end
          default: state_d = sha1_pkg::ST_OUT;
        endcase
      end
      sha1_pkg::ST_ROUND: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == sha1_pkg::LastRound) begin
          rnd_d   = '0;
          state_d = sha1_pkg::ST_FOLD;
        end
      end
      sha1_pkg::ST_FOLD: begin
        if (!fin_q) begin
          state_d = sha1_pkg::ST_IDLE;
        end else if (phase_q == sha1_pkg::PH_DONE) begin
          state_d = sha1_pkg::ST_OUT;
        end else begin
          state_d = sha1_pkg::ST_PAD;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_acc) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == sha1_pkg::LastWord) begin
            oidx_d  = '0;
            fin_d   = 1'b0;
            state_d = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = sha1_pkg::BS_INPUT;
    cmd_o.len_idx   = len_cnt_q;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = oidx_q;
    stall_o         = (state_q != sha1_pkg::ST_IDLE);
    valid_o         = (state_q == sha1_pkg::ST_OUT);
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        cmd_o.absorb    = in_acc && act_absorb;
        cmd_o.count_len = in_acc && act_absorb;
      end
      sha1_pkg::ST_PAD: begin
        unique case (phase_q)
          sha1_pkg::PH_MARK: begin
            cmd_o.absorb   = 1'b1;
            cmd_o.byte_sel = sha1_pkg::BS_MARK;
          end
          sha1_pkg::PH_ZERO: begin
            cmd_o.absorb   = !fill_len;
            cmd_o.byte_sel = sha1_pkg::BS_ZERO;
          end
          sha1_pkg::PH_LEN: begin
            cmd_o.absorb   = 1'b1;
            cmd_o.byte_sel = sha1_pkg::BS_LEN;
          end
          default: cmd_o.absorb = 1'b0;
        endcase
      end
      sha1_pkg::ST_ROUND: cmd_o.round_en = 1'b1;
      sha1_pkg::ST_FOLD:  cmd_o.fold     = 1'b1;
      sha1_pkg::ST_OUT:   cmd_o.restart  = out_acc && (oidx_q == sha1_pkg::LastWord);
      default:            cmd_o.absorb   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1_pkg::ST_IDLE;
      phase_q   <= sha1_pkg::PH_MARK;
      fin_q     <= 1'b0;
      rnd_q     <= '0;
      len_cnt_q <= sha1_pkg::LenBytesHi;
      oidx_q    <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      rnd_q     <= rnd_d;
      len_cnt_q <= len_cnt_d;
      oidx_q    <= oidx_d;
    end
  end

endmodule

// ===== hdl/sha1_dp.sv =====
// SHA-1 datapath: byte packing line, message schedule, round unit, chaining words.
// Depends on sha1_pkg; commanded by sha1_ctrl.
module sha1_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sha1_pkg::dp_cmd_t             cmd_i,
  output sha1_pkg::dp_sts_t             sts_o,
  input  logic [sha1_pkg::ByteW-1:0]    data_byte_i,
  output logic [sha1_pkg::WordW-1:0]    digest_word_o
);

  logic [sha1_pkg::BlkW-1:0]                       blk_q, blk_d;
  logic [sha1_pkg::NumH-1:0][sha1_pkg::WordW-1:0]  h_q, h_d;
  logic [sha1_pkg::WordW-1:0]                      a_q, b_q, c_q, d_q, e_q;
  logic [sha1_pkg::WordW-1:0]                      a_d, b_d, c_d, d_d, e_d;
  logic [sha1_pkg::FillW-1:0]                      fill_q, fill_d;
  logic [sha1_pkg::LenW-1:0]                       len_q, len_d;

  logic [sha1_pkg::ByteW-1:0] byte_in;
  logic [sha1_pkg::WordW-1:0] a_in, b_in, c_in, d_in, e_in;
  logic [sha1_pkg::WordW-1:0] wt, wx, w_new, tmp;
  logic                       first;

  always_comb begin
    unique case (cmd_i.byte_sel)
      sha1_pkg::BS_INPUT: byte_in = data_byte_i;
      sha1_pkg::BS_MARK:  byte_in = sha1_pkg::PadMark;
      sha1_pkg::BS_ZERO:  byte_in = sha1_pkg::PadZero;
      sha1_pkg::BS_LEN:   byte_in = len_q[{cmd_i.len_idx, 3'b000} +: sha1_pkg::ByteW];
      default:            byte_in = sha1_pkg::PadZero;
    endcase
  end

  assign first = (cmd_i.round_idx == '0);
  assign a_in  = first ? h_q[0] : a_q;
  assign b_in  = first ? h_q[1] : b_q;
  assign c_in  = first ? h_q[2] : c_q;
  assign d_in  = first ? h_q[3] : d_q;
  assign e_in  = first ? h_q[4] : e_q;

  assign wt    = blk_q[511:480];
  assign wx    = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
  assign w_new = {wx[30:0], wx[31]};
  assign tmp   = {a_in[26:0], a_in[31:27]} +
                 sha1_pkg::round_f(cmd_i.round_idx, b_in, c_in, d_in) +
                 e_in + wt + sha1_pkg::round_k(cmd_i.round_idx);

  always_comb begin
    blk_d  = blk_q;
    fill_d = fill_q;
    len_d  = len_q;
    h_d    = h_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    d_d    = d_q;
    e_d    = e_q;
    if (cmd_i.absorb) begin
      blk_d  = {blk_q[sha1_pkg::BlkW-sha1_pkg::ByteW-1:0], byte_in};
      fill_d = fill_q + 6'd1;
    end
    if (cmd_i.count_len) len_d = len_q + 64'd8;
    if (cmd_i.round_en) begin
      blk_d = {blk_q[sha1_pkg::BlkW-sha1_pkg::WordW-1:0], w_new};
      a_d   = tmp;
      b_d   = a_in;
      c_d   = {b_in[1:0], b_in[31:2]};
      d_d   = c_in;
      e_d   = d_in;
    end
    if (cmd_i.fold) begin
      h_d[0] = h_q[0] + a_q;
      h_d[1] = h_q[1] + b_q;
      h_d[2] = h_q[2] + c_q;
      h_d[3] = h_q[3] + d_q;
      h_d[4] = h_q[4] + e_q;
    end
    if (cmd_i.restart) begin
      h_d    = sha1_pkg::H_INIT;
      fill_d = '0;
      len_d  = '0;
    end
  end

  always_comb begin
    unique case (cmd_i.out_idx)
      3'd0:    digest_word_o = h_q[0];
      3'd1:    digest_word_o = h_q[1];
      3'd2:    digest_word_o = h_q[2];
      3'd3:    digest_word_o = h_q[3];
      3'd4:    digest_word_o = h_q[4];
      default: digest_word_o = h_q[0];
    endcase
  end

  assign sts_o.fill = fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= sha1_pkg::H_INIT;
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      h_q    <= h_d;
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

endmodule

// ===== hdl/sha1_message_hasher.sv =====
// SHA-1 over a byte stream, one byte per request; a finish request pads the
// message and returns the five digest words, most significant first. A plain
// byte request is taken at once while the hasher is idle; the 64th byte of a
// block starts the 80-round compression (one round per cycle) and the fold into
// the chaining words, during which further requests are stalled. A finish then
// feeds 9 to 72 padding and length bytes through the same byte path, with one
// or two more compressions, before the digest words appear.
// Depends on sha1_pkg, sha1_ctrl and sha1_dp.
module sha1_message_hasher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [sha1_pkg::ActW-1:0]     action_i,
  input  logic [sha1_pkg::ByteW-1:0]    data_byte_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [sha1_pkg::WordW-1:0]    digest_word_o,
  output logic [sha1_pkg::IdxW-1:0]     word_index_o,
  output logic                          last_word_o
);

  sha1_pkg::dp_cmd_t cmd;
  sha1_pkg::dp_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .stall_o  (stall_o),
    .action_i (action_i),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  sha1_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .digest_word_o (digest_word_o)
  );

  assign word_index_o = cmd.out_idx;
  assign last_word_o  = (cmd.out_idx == sha1_pkg::LastWord);

`ifndef ASSERT_OFF
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o |-> !valid_o) else $error("output valid while taking requests");

  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> (word_index_o == '0)) else $error("digest does not start at word 0");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (word_index_o <= sha1_pkg::LastWord)) else $error("word index out of range");

  a_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && last_word_o) |=> (!stall_o && !valid_o))
    else $error("not idle after last digest word");
`endif

endmodule
